// File: design/bpc_pkg.sv
package bpc_pkg;

   localparam int TIME_BITS = 16;
   localparam int CFG_BITS  = 16;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   localparam logic [2:0] ST_UNDEF     = 3'd0;
   localparam logic [2:0] ST_DEB_REL   = 3'd1;
   localparam logic [2:0] ST_DEB_PRESS = 3'd2;
   localparam logic [2:0] ST_RELEASED  = 3'd3;
   localparam logic [2:0] ST_PRESSED   = 3'd4;
   localparam logic [2:0] ST_LONG      = 3'd5;
   localparam logic [2:0] ST_XLONG     = 3'd6;
   localparam logic [2:0] ST_DISABLED  = 3'd7;

   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_PRESSED  = 3'd1;
   localparam logic [2:0] EV_RELEASED = 3'd2;
   localparam logic [2:0] EV_LONG     = 3'd3;
   localparam logic [2:0] EV_XLONG    = 3'd4;

   localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
   localparam logic [1:0] REG_LONG       = 2'd1;
   localparam logic [1:0] REG_EXTRA_LONG = 2'd2;
   localparam logic [1:0] REG_ACTIVE     = 2'd3;

   typedef struct packed {
      logic        raw_level;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic       is_held;
      logic [2:0] state_code;
   } rsp_type;

   function automatic logic [TIME_BITS-1:0] load_time(input logic [CFG_BITS-1:0] v);
      logic [32:0] w;
      w = 33'(v);
      if (w > 33'(TIME_MAX)) begin
         return TIME_MAX;
      end
      return TIME_BITS'(w);
   endfunction

endpackage

// File: design/button_press_classifier_top.sv
// Button press classifier.
// req channel: one pin sample (raw_level) and the milliseconds since the
// previous sample (elapsed_ms) per transfer, valid/ready handshake.
// rsp channel: exactly one result per accepted sample: event code, held flag
// and the state after the sample, valid/ready handshake.
// csr port: write-only, csr_we with csr_index 0 debounce, 1 long press,
// 2 extra-long press, 3 active level; write only while the block is idle.
// The result is registered and shown in the cycle after the sample is accepted.
// Throughput: one sample per cycle unless the receiver stalls; the state machine,
// the countdown and the result register all update in the cycle of the transfer.
// Reset (synchronous, active high): registers return to 50 / 1000 / 3000 ms
// and active level low, the machine to the undefined state, the timer to zero
// and the result register empties.
// When the receiver stalls the result is held and a new sample is taken only
// in a cycle where the waiting result is being transferred.
module button_press_classifier_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  bpc_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output bpc_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_index,
   input  logic [bpc_pkg::CFG_BITS-1:0]       csr_wdata
);

   logic [bpc_pkg::CFG_BITS-1:0]  debounce_ff;
   logic [bpc_pkg::CFG_BITS-1:0]  long_ff;
   logic [bpc_pkg::CFG_BITS-1:0]  xlong_ff;
   logic                          active_ff;

   logic [2:0]                    state_ff,  state_in;
   logic [2:0]                    prev_ff,   prev_in;
   logic [bpc_pkg::TIME_BITS-1:0] remain_ff, remain_in;
   logic                          rsp_valid_ff;
   bpc_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic       accept;
   logic       act;
   logic [2:0] ev;
   logic [2:0] st;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign act       = (req_data.raw_level == active_ff);

   always_comb begin
      st        = state_ff;
      prev_in   = prev_ff;
      ev        = bpc_pkg::EV_NONE;
      if (state_ff == bpc_pkg::ST_UNDEF) begin
         st      = act ? bpc_pkg::ST_DEB_PRESS : bpc_pkg::ST_DEB_REL;
         prev_in = bpc_pkg::ST_DISABLED;
      end
      if (33'(remain_ff) >= 33'(req_data.elapsed_ms)) begin
         remain_in = bpc_pkg::TIME_BITS'(33'(remain_ff) - 33'(req_data.elapsed_ms));
      end else begin
         remain_in = '0;
      end
      state_in = st;
      unique case (st)
         bpc_pkg::ST_DEB_REL: begin
            if (act) begin
               state_in  = bpc_pkg::ST_DEB_PRESS;
               remain_in = bpc_pkg::load_time(debounce_ff);
            end else if (remain_in == '0) begin
               state_in = bpc_pkg::ST_RELEASED;
               if (prev_in != bpc_pkg::ST_RELEASED) begin
                  ev = bpc_pkg::EV_RELEASED;
               end
            end
         end
         bpc_pkg::ST_DEB_PRESS: begin
            if (act) begin
               if (remain_in == '0) begin
                  if (prev_in == bpc_pkg::ST_PRESSED) begin
                     remain_in = bpc_pkg::load_time(long_ff);
                     state_in  = bpc_pkg::ST_PRESSED;
                  end else if (prev_in == bpc_pkg::ST_LONG) begin
                     remain_in = bpc_pkg::load_time(xlong_ff);
                     state_in  = bpc_pkg::ST_LONG;
                  end else if (prev_in == bpc_pkg::ST_XLONG) begin
                     state_in = bpc_pkg::ST_XLONG;
                  end else begin
                     remain_in = bpc_pkg::load_time(long_ff);
                     state_in  = bpc_pkg::ST_PRESSED;
                     ev        = bpc_pkg::EV_PRESSED;
                  end
               end
            end else begin
               remain_in = bpc_pkg::load_time(debounce_ff);
               state_in  = bpc_pkg::ST_RELEASED;
            end
         end
         bpc_pkg::ST_RELEASED: begin
            if (act) begin
               prev_in   = bpc_pkg::ST_RELEASED;
               state_in  = bpc_pkg::ST_DEB_PRESS;
               remain_in = bpc_pkg::load_time(debounce_ff);
            end
         end
         bpc_pkg::ST_PRESSED: begin
            if (act) begin
               if (remain_in == '0) begin
                  remain_in = bpc_pkg::load_time(xlong_ff);
                  state_in  = bpc_pkg::ST_LONG;
                  ev        = bpc_pkg::EV_LONG;
               end
            end else begin
               prev_in   = bpc_pkg::ST_PRESSED;
               state_in  = bpc_pkg::ST_DEB_REL;
               remain_in = bpc_pkg::load_time(debounce_ff);
            end
         end
         bpc_pkg::ST_LONG: begin
            if (act) begin
               if (remain_in == '0) begin
                  state_in = bpc_pkg::ST_XLONG;
                  ev       = bpc_pkg::EV_XLONG;
               end
            end else begin
               prev_in   = bpc_pkg::ST_LONG;
               state_in  = bpc_pkg::ST_DEB_REL;
               remain_in = bpc_pkg::load_time(debounce_ff);
            end
         end
         bpc_pkg::ST_XLONG: begin
            if (!act) begin
               prev_in   = bpc_pkg::ST_XLONG;
               state_in  = bpc_pkg::ST_DEB_REL;
               remain_in = bpc_pkg::load_time(debounce_ff);
            end
         end
         default: begin
         end
      endcase
      rsp_data_in.event_code = ev;
      rsp_data_in.is_held    = (state_in == bpc_pkg::ST_PRESSED) ||
                               (state_in == bpc_pkg::ST_LONG) ||
                               (state_in == bpc_pkg::ST_XLONG);
      rsp_data_in.state_code = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= bpc_pkg::CFG_BITS'(50);
         long_ff      <= bpc_pkg::CFG_BITS'(1000);
         xlong_ff     <= bpc_pkg::CFG_BITS'(3000);
         active_ff    <= 1'b0;
         state_ff     <= bpc_pkg::ST_UNDEF;
         prev_ff      <= bpc_pkg::ST_DISABLED;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               bpc_pkg::REG_DEBOUNCE:   debounce_ff <= csr_wdata;
               bpc_pkg::REG_LONG:       long_ff     <= csr_wdata;
               bpc_pkg::REG_EXTRA_LONG: xlong_ff    <= csr_wdata;
               bpc_pkg::REG_ACTIVE:     active_ff   <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         // advance the machine on each sample transfer
         if (accept) begin
            state_ff  <= state_in;
            prev_ff   <= prev_in;
            remain_ff <= remain_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: verif/button_press_classifier_top_tb.sv
module button_press_classifier_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   bpc_pkg::req_type             req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   bpc_pkg::rsp_type             rsp_data;
   logic                         csr_we = 1'b0;
   logic [1:0]                   csr_index = bpc_pkg::REG_DEBOUNCE;
   logic [bpc_pkg::CFG_BITS-1:0] csr_wdata = '0;

   logic [bpc_pkg::CFG_BITS-1:0]  cfg_debounce = 16'd50;
   logic [bpc_pkg::CFG_BITS-1:0]  cfg_long = 16'd1000;
   logic [bpc_pkg::CFG_BITS-1:0]  cfg_extra_long = 16'd3000;
   logic                          cfg_active = 1'b0;
   logic [2:0]                    btn_state = bpc_pkg::ST_UNDEF;
   logic [2:0]                    last_stable = bpc_pkg::ST_DISABLED;
   logic [bpc_pkg::TIME_BITS-1:0] countdown = '0;

   bpc_pkg::rsp_type awaited_rsp[$];
   bpc_pkg::rsp_type want_rsp;
   int               mismatch_count = 0;
   logic             tx_idle_on = 1'b1;
   logic             rx_idle_on = 1'b1;

   button_press_classifier_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [bpc_pkg::TIME_BITS-1:0] capped_time(
      input logic [bpc_pkg::CFG_BITS-1:0] v);
      if (v > bpc_pkg::TIME_MAX) begin
         return bpc_pkg::TIME_MAX;
      end
      return bpc_pkg::TIME_BITS'(v);
   endfunction

   function automatic bpc_pkg::rsp_type classify_sample(input bpc_pkg::req_type s);
      logic             act;
      logic [2:0]       ev;
      bpc_pkg::rsp_type r;
      act = (s.raw_level == cfg_active);
      ev = bpc_pkg::EV_NONE;
      if (btn_state == bpc_pkg::ST_UNDEF) begin
         btn_state = act ? bpc_pkg::ST_DEB_PRESS : bpc_pkg::ST_DEB_REL;
         last_stable = bpc_pkg::ST_DISABLED;
      end
      countdown = (countdown >= s.elapsed_ms) ? countdown - s.elapsed_ms : '0;
      case (btn_state)
         bpc_pkg::ST_DEB_REL: begin
            if (act) begin
               btn_state = bpc_pkg::ST_DEB_PRESS;
               countdown = capped_time(cfg_debounce);
            end else if (countdown == '0) begin
               btn_state = bpc_pkg::ST_RELEASED;
               if (last_stable != bpc_pkg::ST_RELEASED) begin
                  ev = bpc_pkg::EV_RELEASED;
               end
            end
         end
         bpc_pkg::ST_DEB_PRESS: begin
            if (!act) begin
               countdown = capped_time(cfg_debounce);
               btn_state = bpc_pkg::ST_RELEASED;
            end else if (countdown == '0) begin
               if (last_stable == bpc_pkg::ST_LONG) begin
                  countdown = capped_time(cfg_extra_long);
                  btn_state = bpc_pkg::ST_LONG;
               end else if (last_stable == bpc_pkg::ST_XLONG) begin
                  btn_state = bpc_pkg::ST_XLONG;
               end else begin
                  countdown = capped_time(cfg_long);
                  btn_state = bpc_pkg::ST_PRESSED;
                  if (last_stable != bpc_pkg::ST_PRESSED) begin
                     ev = bpc_pkg::EV_PRESSED;
                  end
               end
            end
         end
         bpc_pkg::ST_RELEASED: begin
            if (act) begin
               last_stable = bpc_pkg::ST_RELEASED;
               btn_state = bpc_pkg::ST_DEB_PRESS;
               countdown = capped_time(cfg_debounce);
            end
         end
         bpc_pkg::ST_PRESSED, bpc_pkg::ST_LONG: begin
            if (!act) begin
               last_stable = btn_state;
               btn_state = bpc_pkg::ST_DEB_REL;
               countdown = capped_time(cfg_debounce);
            end else if (countdown == '0) begin
               if (btn_state == bpc_pkg::ST_PRESSED) begin
                  countdown = capped_time(cfg_extra_long);
                  btn_state = bpc_pkg::ST_LONG;
                  ev = bpc_pkg::EV_LONG;
               end else begin
                  btn_state = bpc_pkg::ST_XLONG;
                  ev = bpc_pkg::EV_XLONG;
               end
            end
         end
         bpc_pkg::ST_XLONG: begin
            if (!act) begin
               last_stable = bpc_pkg::ST_XLONG;
               btn_state = bpc_pkg::ST_DEB_REL;
               countdown = capped_time(cfg_debounce);
            end
         end
         default: begin
         end
      endcase
      r.event_code = ev;
      r.is_held = (btn_state inside {bpc_pkg::ST_PRESSED, bpc_pkg::ST_LONG,
                                     bpc_pkg::ST_XLONG});
      r.state_code = btn_state;
      return r;
   endfunction

   task automatic send_sample(input logic lvl, input logic [15:0] ms);
      bpc_pkg::req_type s;
      s.raw_level = lvl;
      s.elapsed_ms = ms;
      while (tx_idle_on && $urandom_range(0, 99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= s;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      awaited_rsp.push_back(classify_sample(s));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic set_config(input logic [15:0] deb, input logic [15:0] lng,
                             input logic [15:0] xl, input logic act);
      csr_we <= 1'b1;
      csr_index <= bpc_pkg::REG_DEBOUNCE;
      csr_wdata <= deb;
      @(posedge clock);
      csr_index <= bpc_pkg::REG_LONG;
      csr_wdata <= lng;
      @(posedge clock);
      csr_index <= bpc_pkg::REG_EXTRA_LONG;
      csr_wdata <= xl;
      @(posedge clock);
      csr_index <= bpc_pkg::REG_ACTIVE;
      csr_wdata <= bpc_pkg::CFG_BITS'(act);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_debounce = deb;
      cfg_long = lng;
      cfg_extra_long = xl;
      cfg_active = act;
   endtask

   task automatic press_episodes(input int n_items, input int step_cap);
      int         sent;
      int         hold_on;
      int         hold_off;
      logic       lvl;
      logic [15:0] ms;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 15) begin
            send_sample(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
            sent++;
         end else begin
            hold_on = $urandom_range(1, 20);
            hold_off = $urandom_range(1, 8);
            for (int k = 0; k < hold_on + hold_off; k++) begin
               lvl = (k < hold_on) ? cfg_active : ~cfg_active;
               if ($urandom_range(0, 99) < 10) begin
                  lvl = ~lvl;
               end
               if ($urandom_range(0, 15) == 0) begin
                  ms = 16'($urandom_range(0, 65535));
               end else begin
                  ms = 16'($urandom_range(0, step_cap));
               end
               send_sample(lvl, ms);
               sent++;
            end
         end
      end
   endtask

   task automatic report(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= !(rx_idle_on && $urandom_range(0, 99) < 6);
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transfer, expected none, actual %p", $time, rsp_data);
         end else begin
            want_rsp = awaited_rsp.pop_front();
            if (rsp_data.event_code !== want_rsp.event_code) begin
               report("event_code", want_rsp.event_code, rsp_data.event_code);
            end
            if (rsp_data.is_held !== want_rsp.is_held) begin
               report("is_held", want_rsp.is_held, rsp_data.is_held);
            end
            if (rsp_data.state_code !== want_rsp.state_code) begin
               report("state_code", want_rsp.state_code, rsp_data.state_code);
            end
         end
      end
   end

   task automatic test_first_sample();
      send_sample(1'b1, 16'd0);
   endtask

   task automatic test_hold_sequence();
      wait_idle();
      set_config(16'd3, 16'd5, 16'd4, 1'b1);
      send_sample(1'b1, 16'd0);
      send_sample(1'b0, 16'd1);
      send_sample(1'b1, 16'd0);
      send_sample(1'b1, 16'hFFFF);
      send_sample(1'b1, 16'd5);
      send_sample(1'b0, 16'd0);
      send_sample(1'b1, 16'd0);
      send_sample(1'b1, 16'd3);
      send_sample(1'b1, 16'hFFFF);
      send_sample(1'b0, 16'd1);
      send_sample(1'b1, 16'd0);
      send_sample(1'b1, 16'd7);
      send_sample(1'b0, 16'd0);
      send_sample(1'b0, 16'hFFFF);
      send_sample(1'b1, 16'd2);
      send_sample(1'b1, 16'hAAAA);
      send_sample(1'b0, 16'd0);
      send_sample(1'b1, 16'd1);
      send_sample(1'b1, 16'h5555);
   endtask

   task automatic test_zero_times();
      wait_idle();
      set_config(16'd0, 16'd0, 16'd0, 1'b0);
      send_sample(1'b0, 16'd0);
      send_sample(1'b0, 16'd0);
      send_sample(1'b0, 16'd0);
      send_sample(1'b1, 16'd0);
      send_sample(1'b1, 16'd0);
   endtask

   task automatic test_random_short_times();
      wait_idle();
      set_config(16'($urandom_range(2, 6)), 16'($urandom_range(3, 15)),
                 16'($urandom_range(3, 15)), 1'($urandom_range(0, 1)));
      press_episodes(200, 4);
      wait_idle();
      press_episodes(200, 4);
   endtask

   task automatic test_back_to_back();
      wait_idle();
      set_config(16'($urandom_range(0, 8)), 16'($urandom_range(0, 20)),
                 16'($urandom_range(0, 20)), 1'b0);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      press_episodes(250, 5);
      wait_idle();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   task automatic test_maximum_times();
      wait_idle();
      set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      press_episodes(150, 65535);
   endtask

   task automatic test_zero_random();
      wait_idle();
      set_config(16'd0, 16'd0, 16'd0, 1'b0);
      press_episodes(150, 3);
   endtask

   task automatic test_random_configs();
      for (int p = 0; p < 4; p++) begin
         wait_idle();
         set_config(16'($urandom_range(0, 50)), 16'($urandom_range(0, 50)),
                    16'($urandom_range(0, 50)), 1'($urandom_range(0, 1)));
         press_episodes(150, 20);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_first_sample();
      test_hold_sequence();
      test_zero_times();
      test_random_short_times();
      test_back_to_back();
      test_maximum_times();
      test_zero_random();
      test_random_configs();
      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("** button_press_classifier_top: PASSED **");
      end else begin
         $display("** button_press_classifier_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("** button_press_classifier_top: FAILED **");
      $finish;
   end

endmodule
